@@ hdl/assert_macros.svh @@
// Assertion macros for the checker files of the block (used by cai_chk).
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPLY(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cai_pkg.sv @@
// Shared types and constants of the crank angle interpolator.
// No dependencies; used by cai_ctrl, cai_dp and the top level.
package cai_pkg;

  localparam int unsigned TimeW   = 32;  // timestamp width
  localparam int unsigned IdxW    = 10;  // edge index width
  localparam int unsigned EptW    = 10;  // edges_per_turn register width
  localparam int unsigned ScaleW  = 12;  // bits of the 3600 scale factor
  localparam int unsigned Tenths  = 3600;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned BaseW   = IdxW + ScaleW;   // 3600 * index
  localparam int unsigned NumW    = TimeW + ScaleW;  // 3600 * dt
  localparam int unsigned DivW    = TimeW + EptW;    // period * edges_per_turn
  localparam int unsigned CntW    = $clog2(NumW + 1);
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  localparam logic [EptW-1:0] EptReset = EptW'(115);
  localparam logic            RegEpt   = 1'b0;  // paddr[2] of edges_per_turn

  localparam logic [1:0] CmdEdge  = 2'd0;
  localparam logic [1:0] CmdQuery = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StLoadBase,
    StRunBase,
    StRunFrac,
    StDone
  } state_e;

  typedef struct packed {
    logic edge_we;    // record an edge event
    logic clear;      // clear tracking state
    logic query;      // latch timestamp and readiness of a query
    logic mul;        // register the three products
    logic base_load;  // load divider with 3600*index / edges_per_turn
    logic base_done;  // keep base quotient, load fractional division
    logic div_run;    // advance the divider one bit
    logic out_load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic not_ready;  // no period, no edge time or zero edge count
    logic div_busy;   // divider still has bits to go
    logic out_full;   // result register holds an untaken result
  } sts_t;

endpackage

@@ hdl/crank_angle_interpolator.sv @@
// Crank angle interpolator top level: APB register decode, controller and
// datapath. Depends on cai_pkg, cai_ctrl and cai_dp.
//
// Input channel (in_valid_i / in_stall_o) carries one request: command_i,
// edge_id_i, timestamp_i. Edge events and reset-tracking requests give no
// result. An angle query gives exactly one result on the output channel
// (out_valid_o / out_stall_i): angle_valid_o, angle_tenths_o.
//
// A query holds the input stalled until its result is loaded, so the next request
// is taken only after that. The time taken is set by the single shared restoring
// divider, one quotient bit per cycle: 22 bits for 3600*index/edges_per_turn, then
// 44 bits for 3600*dt/(period*edges_per_turn), with the multiply, divider-load and
// result-load steps around it.
// A query that cannot be answered (no period, no edge time, zero edge count)
// skips the divider, with angle_valid_o low and angle_tenths_o zero.
//
// The result waits in an output register; a stalled receiver holds it, and
// edge and reset requests are still taken meanwhile. A following query stops
// at its last step until the register frees.
// Reset clears tracking state and sets edges_per_turn (byte address 0) to 115.
module crank_angle_interpolator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [cai_pkg::IdxW-1:0]      edge_id_i,
  input  logic [cai_pkg::TimeW-1:0]     timestamp_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          angle_valid_o,
  output logic [cai_pkg::AngleW-1:0]    angle_tenths_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cai_pkg::PaddrW-1:0]    paddr,
  input  logic [cai_pkg::PdataW-1:0]    pwdata,
  output logic [cai_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);

  cai_pkg::cmd_t             cmd;
  cai_pkg::sts_t             sts;
  logic                      cfg_we;
  logic [cai_pkg::EptW-1:0]  ept;

  // Zero wait states; only the register at address 0 exists.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == cai_pkg::RegEpt);
  assign prdata = (paddr[2] == cai_pkg::RegEpt) ? cai_pkg::PdataW'(ept) : '0;

  cai_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  cai_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .edge_id_i      (edge_id_i),
    .timestamp_i    (timestamp_i),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[cai_pkg::EptW-1:0]),
    .ept_o          (ept),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .angle_valid_o  (angle_valid_o),
    .angle_tenths_o (angle_tenths_o)
  );

endmodule

@@ hdl/cai_ctrl.sv @@
// Controller of the crank angle interpolator: sequences one request at a time.
// Depends on cai_pkg (state_e, cmd_t, sts_t, command codes).
module cai_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       command_i,
  input  logic             out_stall_i,
  input  cai_pkg::sts_t    sts_i,
  output cai_pkg::cmd_t    cmd_o,
  output logic             in_stall_o
);

  cai_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cai_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cai_pkg::StIdle: begin
        if (in_valid_i && command_i == cai_pkg::CmdQuery) begin
          state_d = sts_i.not_ready ? cai_pkg::StDone : cai_pkg::StMul;
        end
      end
      cai_pkg::StMul:      state_d = cai_pkg::StLoadBase;
      cai_pkg::StLoadBase: state_d = cai_pkg::StRunBase;
      cai_pkg::StRunBase: begin
        if (!sts_i.div_busy) state_d = cai_pkg::StRunFrac;
      end
      cai_pkg::StRunFrac: begin
        if (!sts_i.div_busy) state_d = cai_pkg::StDone;
      end
      cai_pkg::StDone: begin
        if (!sts_i.out_full || !out_stall_i) state_d = cai_pkg::StIdle;
      end
      default: state_d = cai_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      cai_pkg::StIdle: begin
        in_stall_o    = 1'b0;
        cmd_o.edge_we = in_valid_i && command_i == cai_pkg::CmdEdge;
        cmd_o.clear   = in_valid_i && command_i == cai_pkg::CmdClear;
        cmd_o.query   = in_valid_i && command_i == cai_pkg::CmdQuery;
      end
      cai_pkg::StMul:      cmd_o.mul = 1'b1;
      cai_pkg::StLoadBase: cmd_o.base_load = 1'b1;
      cai_pkg::StRunBase: begin
        cmd_o.div_run   = 1'b1;
        cmd_o.base_done = !sts_i.div_busy;
      end
      cai_pkg::StRunFrac:  cmd_o.div_run = 1'b1;
      cai_pkg::StDone:     cmd_o.out_load = !sts_i.out_full || !out_stall_i;
      default: ;
    endcase
  end

endmodule

@@ hdl/cai_dp.sv @@
// Datapath of the crank angle interpolator: tracking state, products,
// shared restoring divider and result register. Depends on cai_pkg.
module cai_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cai_pkg::cmd_t               cmd_i,
  output cai_pkg::sts_t               sts_o,
  input  logic [cai_pkg::IdxW-1:0]    edge_id_i,
  input  logic [cai_pkg::TimeW-1:0]   timestamp_i,
  input  logic                        cfg_we_i,
  input  logic [cai_pkg::EptW-1:0]    cfg_wdata_i,
  output logic [cai_pkg::EptW-1:0]    ept_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        angle_valid_o,
  output logic [cai_pkg::AngleW-1:0]  angle_tenths_o
);

  logic [cai_pkg::EptW-1:0]   ept_q;
  logic [cai_pkg::IdxW-1:0]   idx_q;
  logic [cai_pkg::TimeW-1:0]  time_q, period_q, ts_q;
  logic                       qvalid_q;

  logic [cai_pkg::BaseW-1:0]  base_prod_q, base_q;
  logic [cai_pkg::NumW-1:0]   scaled_q, num_q, num_d;
  logic [cai_pkg::DivW-1:0]   divisor_q, div_q, rem_q, rem_d;
  logic [cai_pkg::CntW-1:0]   cnt_q;

  logic [cai_pkg::TimeW-1:0]  dt;
  logic [cai_pkg::DivW:0]     trial;
  logic                       ge;

  logic [cai_pkg::BaseW:0]    sum;
  logic                       sat;
  logic [cai_pkg::AngleW-1:0] angle;

  logic                       out_valid_q, angle_valid_q;
  logic [cai_pkg::AngleW-1:0] angle_tenths_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ept_q <= cai_pkg::EptReset;
    end else if (cfg_we_i) begin
      ept_q <= cfg_wdata_i;
    end
  end

  // Tracking state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '1;
      time_q   <= '0;
      period_q <= '0;
    end else if (cmd_i.clear) begin
      idx_q    <= '1;
      time_q   <= '0;
      period_q <= '0;
    end else if (cmd_i.edge_we && (cai_pkg::EptW'(edge_id_i) < ept_q)) begin
      idx_q  <= edge_id_i;
      time_q <= timestamp_i;
      if (time_q != '0) period_q <= timestamp_i - time_q;
    end
  end

  assign sts_o.not_ready = (period_q == '0) || (time_q == '0) || (ept_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      ts_q     <= timestamp_i;
      qvalid_q <= !sts_o.not_ready;
    end
  end

  assign dt = ts_q - time_q;

  // Products, one register stage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      base_prod_q <= cai_pkg::BaseW'(idx_q) * cai_pkg::BaseW'(cai_pkg::Tenths);
      scaled_q    <= cai_pkg::NumW'(dt) * cai_pkg::NumW'(cai_pkg::Tenths);
      divisor_q   <= cai_pkg::DivW'(period_q) * cai_pkg::DivW'(ept_q);
    end
  end

  // Restoring divider, one quotient bit per cycle; quotient shifts into num.
  assign trial = {rem_q, num_q[cai_pkg::NumW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign rem_d = ge ? cai_pkg::DivW'(trial - {1'b0, div_q}) : trial[cai_pkg::DivW-1:0];
  assign num_d = {num_q[cai_pkg::NumW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.base_load) begin
      cnt_q <= cai_pkg::CntW'(cai_pkg::BaseW);
    end else if (cmd_i.base_done) begin
      cnt_q <= cai_pkg::CntW'(cai_pkg::NumW);
    end else if (cmd_i.div_run && cnt_q != '0) begin
      cnt_q <= cnt_q - cai_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.base_load) begin
      num_q <= {base_prod_q, (cai_pkg::NumW - cai_pkg::BaseW)'(0)};
      div_q <= cai_pkg::DivW'(ept_q);
      rem_q <= '0;
    end else if (cmd_i.base_done) begin
      base_q <= num_q[cai_pkg::BaseW-1:0];
      num_q  <= scaled_q;
      div_q  <= divisor_q;
      rem_q  <= '0;
    end else if (cmd_i.div_run && cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign sts_o.div_busy = cnt_q != '0;

  // Saturating sum of base and fraction.
  assign sum   = (cai_pkg::BaseW + 1)'(base_q) +
                 (cai_pkg::BaseW + 1)'(num_q[cai_pkg::AngleW-1:0]);
  assign sat   = (|num_q[cai_pkg::NumW-1:cai_pkg::AngleW]) ||
                 (|sum[cai_pkg::BaseW:cai_pkg::AngleW]);
  assign angle = sat ? '1 : sum[cai_pkg::AngleW-1:0];

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      angle_valid_q  <= qvalid_q;
      angle_tenths_q <= qvalid_q ? angle : '0;
    end
  end

  assign sts_o.out_full  = out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign angle_valid_o   = angle_valid_q;
  assign angle_tenths_o  = angle_tenths_q;
  assign ept_o           = ept_q;

endmodule

@@ hdl/cai_chk.sv @@
// Port-level checker of the crank angle interpolator, bound to the top level.
// Depends on assert_macros.svh and cai_pkg.
`include "assert_macros.svh"

module cai_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [1:0]                   command_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         angle_valid_o,
  input logic [cai_pkg::AngleW-1:0]   angle_tenths_o
);

  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(angle_valid_o) && $stable(angle_tenths_o),
    "stalled result changed")

  `ASSERT_IMPLY(a_invalid_zero, out_valid_o && !angle_valid_o, angle_tenths_o == '0,
    "invalid angle carries nonzero value")

  `ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && command_i == cai_pkg::CmdQuery,
    in_stall_o, "query did not occupy the block")

  `ASSERT_NEXT(a_edge_single, in_valid_i && !in_stall_o && command_i != cai_pkg::CmdQuery,
    !in_stall_o, "edge or reset request stalled the input")

endmodule

bind crank_angle_interpolator cai_chk u_cai_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .command_i      (command_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .angle_valid_o  (angle_valid_o),
  .angle_tenths_o (angle_tenths_o)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench of crank_angle_interpolator: directed table, then random requests.
// Predicts every angle query in place and checks results as they leave the block.
// Depends on cai_pkg and the crank_angle_interpolator RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth command code is unused; the block drops it without a result.
  localparam logic [1:0]                 CmdUnused  = 2'd3;
  localparam logic [cai_pkg::PaddrW-1:0] AddrEpt    = cai_pkg::PaddrW'(0);
  localparam logic [cai_pkg::PaddrW-1:0] AddrBeyond = cai_pkg::PaddrW'(4);
  // Cycles to wait before touching the register.
  localparam int unsigned                Settle     = 100;
  localparam int unsigned                HoldOff    = 400;
  localparam int unsigned                IdleLimit  = 4000;
  localparam int unsigned                ReportMax  = 10;
  localparam logic [cai_pkg::AngleW-1:0] AngleMax   = '1;
  localparam int unsigned                DirRows    = 25;

  // One request plus, for some directed rows, an expected result typed in by hand.
  typedef struct packed {
    logic [1:0]                 cmd;
    logic [cai_pkg::IdxW-1:0]   id;
    logic [cai_pkg::TimeW-1:0]  ts;
    logic                       fixed;
    logic                       fix_ok;
    logic [cai_pkg::AngleW-1:0] fix_tenths;
  } request_t;

  typedef struct packed {
    logic                       ok;
    logic [cai_pkg::AngleW-1:0] tenths;
  } angle_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [1:0]                 command_i;
  logic [cai_pkg::IdxW-1:0]   edge_id_i;
  logic [cai_pkg::TimeW-1:0]  timestamp_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic                       angle_valid_o;
  logic [cai_pkg::AngleW-1:0] angle_tenths_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [cai_pkg::PaddrW-1:0] paddr;
  logic [cai_pkg::PdataW-1:0] pwdata;
  logic [cai_pkg::PdataW-1:0] prdata;
  logic                       pready;

  crank_angle_interpolator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .edge_id_i      (edge_id_i),
    .timestamp_i    (timestamp_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .angle_valid_o  (angle_valid_o),
    .angle_tenths_o (angle_tenths_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Tracking state as the block should hold it, plus our copy of edges_per_turn.
  logic [cai_pkg::EptW-1:0]  ept_copy;
  logic [cai_pkg::IdxW-1:0]  trk_index;
  logic [cai_pkg::TimeW-1:0] trk_time;
  logic [cai_pkg::TimeW-1:0] trk_period;

  // Angles owed by the block, oldest first.
  angle_t      pending_angles[$];
  request_t    cur_req;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          calm;          // no random gaps on either side while set; a hold-off still applies
  bit          hold_off_req;  // ask the receiver for one long stall

  // Running tooth wheel used to build well-formed random sequences.
  logic [cai_pkg::IdxW-1:0]  tooth_id;
  logic [cai_pkg::TimeW-1:0] tooth_time;
  logic [cai_pkg::TimeW-1:0] tooth_period;

  // Directed requests: cmd, edge id, timestamp, typed-in flag, valid, angle.
  // Rows without a typed result go through the angle predictor.
  request_t dir_tab [DirRows] = '{
    // nothing known after reset
    '{cai_pkg::CmdQuery, 10'd0,    32'd0,           1'b1, 1'b0, 16'd0},
    // an edge at time zero is stored but reads as no edge
    '{cai_pkg::CmdEdge,  10'd0,    32'd0,           1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdQuery, 10'd0,    32'd5,           1'b1, 1'b0, 16'd0},
    // first real edge: time only, no period yet
    '{cai_pkg::CmdEdge,  10'd1,    32'd1000,        1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdQuery, 10'd0,    32'd1500,        1'b1, 1'b0, 16'd0},
    '{cai_pkg::CmdEdge,  10'd2,    32'd2000,        1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdQuery, 10'd0,    32'd2500,        1'b0, 1'b0, 16'd0},
    // edge ids at or above the edge count are dropped
    '{cai_pkg::CmdEdge,  10'd115,  32'd3000,        1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdEdge,  10'd1023, 32'd3000,        1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdQuery, 10'd0,    32'd2000,        1'b0, 1'b0, 16'd0},
    // query one tick before the edge: dt wraps and the angle saturates
    '{cai_pkg::CmdQuery, 10'd0,    32'd1999,        1'b1, 1'b1, 16'hFFFF},
    '{CmdUnused,         10'd1023, 32'hFFFF_FFFF,   1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdEdge,  10'd114,  32'hFFFF_FFFF,   1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdQuery, 10'd1023, 32'hFFFF_FFFF,   1'b0, 1'b0, 16'd0},
    // the period wraps across the timer overflow
    '{cai_pkg::CmdEdge,  10'd0,    32'h0000_0010,   1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdQuery, 10'd0,    32'h0000_0020,   1'b0, 1'b0, 16'd0},
    // clearing drops edge, time and period
    '{cai_pkg::CmdClear, 10'd1023, 32'hFFFF_FFFF,   1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdQuery, 10'd0,    32'h0000_0020,   1'b1, 1'b0, 16'd0},
    '{cai_pkg::CmdEdge,  10'd3,    32'd100,         1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdEdge,  10'd4,    32'd101,         1'b0, 1'b0, 16'd0},
    // one-tick period, far query: saturate
    '{cai_pkg::CmdQuery, 10'd0,    32'hFFFF_FFFF,   1'b1, 1'b1, 16'hFFFF},
    '{cai_pkg::CmdEdge,  10'd5,    32'd0,           1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdQuery, 10'd0,    32'd200,         1'b1, 1'b0, 16'd0},
    // edge after a zero time keeps the old period
    '{cai_pkg::CmdEdge,  10'd6,    32'h8000_0000,   1'b0, 1'b0, 16'd0},
    '{cai_pkg::CmdQuery, 10'd0,    32'h8000_0007,   1'b0, 1'b0, 16'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Gap length shared by sender and receiver: mostly none or short, a few long.
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm) return 0;
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [cai_pkg::TimeW-1:0] pick_period();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return $urandom_range(1, 200);
    if (pick < 85) return $urandom_range(201, 100000);
    return $urandom_range(100001, 32'hFFFF_FFFF);
  endfunction

  function automatic void clear_tracking();
    trk_index  = '1;
    trk_time   = '0;
    trk_period = '0;
  endfunction

  // Angle the block should report for a query at time ts, from current tracking state.
  function automatic angle_t interpolate(input logic [cai_pkg::TimeW-1:0] ts);
    logic [63:0] base;
    logic [63:0] dt;
    logic [63:0] frac;
    logic [63:0] sum;
    angle_t      a;
    a = '0;
    if (trk_period == '0 || trk_time == '0 || ept_copy == '0) return a;
    base = (64'(cai_pkg::Tenths) * 64'(trk_index)) / 64'(ept_copy);
    dt   = 64'(cai_pkg::TimeW'(ts - trk_time));
    // 3600*dt fits in 44 bits, so no intermediate wraps here
    frac = ((dt * 64'(cai_pkg::Tenths)) / 64'(trk_period)) / 64'(ept_copy);
    sum  = base + frac;
    a.ok     = 1'b1;
    a.tenths = (sum > 64'(AngleMax)) ? AngleMax : sum[cai_pkg::AngleW-1:0];
    return a;
  endfunction

  // Apply one accepted request to the tracking state; queue the angle a query owes.
  function automatic void track_request(input request_t r);
    angle_t owed;
    case (r.cmd)
      cai_pkg::CmdEdge: begin
        if (r.id < cai_pkg::IdxW'(ept_copy)) begin
          trk_index = r.id;
          if (trk_time != '0) trk_period = r.ts - trk_time;
          trk_time = r.ts;
        end
      end
      cai_pkg::CmdClear: clear_tracking();
      cai_pkg::CmdQuery: begin
        owed = interpolate(r.ts);
        if (r.fixed) begin
          owed.ok     = r.fix_ok;
          owed.tenths = r.fix_tenths;
        end
        pending_angles.push_back(owed);
      end
      default: ;
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= ReportMax)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  // Predict at the edge where a request is taken; all reads see pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) track_request(cur_req);
  end

  // Check each result taken from the block against the oldest owed angle.
  always @(posedge clk_i) begin
    angle_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_angles.size() == 0) begin
        flag_mismatch("result with no query pending", 32'd0, 32'(angle_tenths_o));
      end else begin
        want = pending_angles.pop_front();
        if (angle_valid_o !== want.ok)
          flag_mismatch("angle_valid", 32'(want.ok), 32'(angle_valid_o));
        if (angle_tenths_o !== want.tenths)
          flag_mismatch("angle_tenths", 32'(want.tenths), 32'(angle_tenths_o));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = HoldOff;
      end else begin
        n = gap_len();
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel || !rst_ni)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one request after a random gap; return at the edge where it is taken.
  task automatic send_request(input request_t r);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cur_req     <= r;
    command_i   <= r.cmd;
    edge_id_i   <= r.id;
    timestamp_i <= r.ts;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid, drain owed angles, then let edge requests still inside finish.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [cai_pkg::PaddrW-1:0] addr,
                           input logic [cai_pkg::PdataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // write lands at this edge; only index 0 exists
    if (addr == AddrEpt) ept_copy = data[cai_pkg::EptW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_check(input logic [cai_pkg::PaddrW-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== cai_pkg::PdataW'(ept_copy)) flag_mismatch("edges_per_turn readback",
                                                             32'(ept_copy), 32'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Retune edges_per_turn while idle and restart the tooth wheel.
  task automatic configure(input logic [cai_pkg::EptW-1:0] ept);
    wait_quiet();
    reg_write(AddrEpt, cai_pkg::PdataW'(ept));
    reg_check(AddrEpt);
    tooth_id     = '0;
    tooth_time   = $urandom;
    tooth_period = pick_period();
  endtask

  // Mostly consecutive teeth and queries near the last edge; the rest is noise.
  task automatic make_request(output request_t r);
    int unsigned pick;
    logic [63:0] span;
    pick   = $urandom_range(0, 99);
    r      = '0;
    r.cmd  = 2'($urandom);
    r.id   = cai_pkg::IdxW'($urandom);
    r.ts   = $urandom;
    if (pick < 45) begin
      if ($urandom_range(0, 9) == 0) tooth_period = pick_period();
      tooth_id   = (32'(tooth_id) + 1 >= 32'(ept_copy)) ? '0 : tooth_id + 1'b1;
      tooth_time = tooth_time + tooth_period;
      r.cmd = cai_pkg::CmdEdge;
      r.id  = tooth_id;
      r.ts  = tooth_time;
    end else if (pick < 85) begin
      span  = 64'(tooth_period) * 2 + 1;
      r.cmd = cai_pkg::CmdQuery;
      r.ts  = tooth_time + cai_pkg::TimeW'({$urandom, $urandom} % span);
    end else if (pick < 90) begin
      r.cmd = cai_pkg::CmdClear;
    end
  endtask

  task automatic run_random(input int unsigned count);
    request_t r;
    repeat (count) begin
      make_request(r);
      send_request(r);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    command_i    = cai_pkg::CmdEdge;
    edge_id_i    = '0;
    timestamp_i  = '0;
    cur_req      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = AddrEpt;
    pwdata       = '0;
    mismatches   = 0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    ept_copy     = cai_pkg::EptReset;
    clear_tracking();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register comes up at its reset value.
    reg_check(AddrEpt);
    for (int i = 0; i < DirRows; i++) send_request(dir_tab[i]);

    // Largest edge count, then the smallest.
    configure(cai_pkg::EptW'(1023));
    run_random(200);
    configure(cai_pkg::EptW'(1));
    run_random(100);

    // Zero edge count: every edge is dropped and every query is invalid.
    configure(cai_pkg::EptW'(0));
    run_random(30);

    // Writes beyond index 0 leave the register alone.
    wait_quiet();
    reg_write(AddrBeyond, $urandom);
    reg_check(AddrEpt);

    // Mid-range counts, with one stretch free of gaps on both sides.
    configure(cai_pkg::EptW'($urandom_range(2, 1022)));
    calm = 1'b1;
    run_random(80);
    calm = 1'b0;
    run_random(120);
    configure(cai_pkg::EptW'($urandom_range(1, 1023)));
    run_random(150);

    // Back to the reset count; hold the receiver off while requests keep coming.
    configure(cai_pkg::EptReset);
    hold_off_req = 1'b1;
    calm = 1'b1;
    run_random(60);
    calm = 1'b0;
    run_random(140);

    wait_quiet();
    if (mismatches == 0 && pending_angles.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
